FILE: src/glass_tile_address_generator_unit_defines.svh
// Assertion macros shared by the glass-tile address generator modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef GLASS_TILE_ADDRESS_GENERATOR_UNIT_DEFINES_SVH
`define GLASS_TILE_ADDRESS_GENERATOR_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GTAG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GTAG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/gtag_pkg.sv
// Package for the glass-tile address generator: constants, register codes,
// shared structs and the tile size saturation function. No dependencies.
package gtag_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_W     = 12;
    localparam int TILE_W      = 6;
    localparam int ORIGIN_W    = 12;
    localparam int SIZE_W      = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 3;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 48;

    // Default image dimension limit.
    localparam int MAX_SIZE_DEF = 4096;

    // Tile size limits and register reset values.
    localparam logic [TILE_W-1:0] TILE_MIN = 6'd10;
    localparam logic [TILE_W-1:0] TILE_MAX = 6'd50;
    localparam logic [TILE_W-1:0] TILE_RST = 6'd20;
    localparam int REGION_SIZE_RST = 4096;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TILE_WIDTH    = 3'd0,
        REG_TILE_HEIGHT   = 3'd1,
        REG_REGION_LEFT   = 3'd2,
        REG_REGION_TOP    = 3'd3,
        REG_REGION_WIDTH  = 3'd4,
        REG_REGION_HEIGHT = 3'd5
    } gtag_reg_t;

    // Saturated tile geometry, split into the half and the remainder.
    typedef struct packed {
        logic [TILE_W-1:0] tw;
        logic [TILE_W-1:0] th;
        logic [TILE_W-1:0] xhalf;
        logic [TILE_W-1:0] xrem;
        logic [TILE_W-1:0] yhalf;
        logic [TILE_W-1:0] yrem;
    } gtag_tile_t;

    localparam gtag_tile_t TILE_GEOM_RST = '{
        tw:    6'd20,
        th:    6'd20,
        xhalf: 6'd10,
        xrem:  6'd10,
        yhalf: 6'd10,
        yrem:  6'd10
    };

    // One result transaction.
    typedef struct packed {
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic               row_end;
        logic               frame_end;
    } gtag_result_t;

    // Clamp a programmed tile size into the supported range.
    function automatic logic [TILE_W-1:0] sat_tile(input logic [TILE_W-1:0] v);
        logic [TILE_W-1:0] r;
        if (v < TILE_MIN)
        begin
            r = TILE_MIN;
        end
        else if (v > TILE_MAX)
        begin
            r = TILE_MAX;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: src/gtag_cfg.sv
// Configuration registers and the region and tile geometry derived from them.
// Depends on gtag_pkg.
module gtag_cfg #(
    parameter int MAX_SIZE = gtag_pkg::MAX_SIZE_DEF,
    localparam int AW = $clog2(MAX_SIZE)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               we,
    input  logic [gtag_pkg::CFG_INDEX_W-1:0]   index,
    input  logic [gtag_pkg::CFG_DATA_W-1:0]    data,
    output logic [AW-1:0]                      left,
    output logic [AW-1:0]                      top,
    output logic [AW-1:0]                      last_row,
    output logic [AW:0]                        w,
    output logic [AW:0]                        h,
    output gtag_pkg::gtag_tile_t               tile
);

    localparam int EW = ((AW > gtag_pkg::ORIGIN_W) ? AW : gtag_pkg::ORIGIN_W) + 1;
    localparam int SPW = ((AW > gtag_pkg::SIZE_W) ? AW : gtag_pkg::SIZE_W) + 1;
    localparam int RST_SPAN = (MAX_SIZE < gtag_pkg::REGION_SIZE_RST) ? MAX_SIZE
                                                                    : gtag_pkg::REGION_SIZE_RST;

    logic [gtag_pkg::TILE_W-1:0]   tw_raw_reg, tw_raw_next;
    logic [gtag_pkg::TILE_W-1:0]   th_raw_reg, th_raw_next;
    logic [gtag_pkg::ORIGIN_W-1:0] left_raw_reg, left_raw_next;
    logic [gtag_pkg::ORIGIN_W-1:0] top_raw_reg, top_raw_next;
    logic [gtag_pkg::SIZE_W-1:0]   wid_raw_reg, wid_raw_next;
    logic [gtag_pkg::SIZE_W-1:0]   hgt_raw_reg, hgt_raw_next;

    logic [AW-1:0]        left_reg, left_next;
    logic [AW-1:0]        top_reg, top_next;
    logic [AW-1:0]        last_row_reg, last_row_next;
    logic [AW:0]          w_reg, w_next;
    logic [AW:0]          h_reg, h_next;
    gtag_pkg::gtag_tile_t tile_reg, tile_next;
    logic [AW:0]          last_row_wide;

    // Usable pixels along one axis from a saturated origin.
    function automatic logic [AW:0] span_of(input logic [AW-1:0] origin,
                                            input logic [gtag_pkg::SIZE_W-1:0] size);
        logic [gtag_pkg::SIZE_W-1:0] sz;
        logic [SPW-1:0]              fin;
        logic [SPW-1:0]              diff;
        sz = (size == '0) ? gtag_pkg::SIZE_W'(1) : size;
        fin = SPW'(origin) + SPW'(sz);
        if (fin > SPW'(MAX_SIZE))
        begin
            fin = SPW'(MAX_SIZE);
        end
        diff = fin - SPW'(origin);
        return diff[AW:0];
    endfunction

    // Clamp an origin to the last addressable position.
    function automatic logic [AW-1:0] sat_origin(input logic [gtag_pkg::ORIGIN_W-1:0] v);
        logic [AW-1:0] r;
        if (EW'(v) > EW'(MAX_SIZE - 1))
        begin
            r = AW'(MAX_SIZE - 1);
        end
        else
        begin
            r = AW'(v);
        end
        return r;
    endfunction

    // Register write decode.
    always_comb
    begin
        tw_raw_next   = tw_raw_reg;
        th_raw_next   = th_raw_reg;
        left_raw_next = left_raw_reg;
        top_raw_next  = top_raw_reg;
        wid_raw_next  = wid_raw_reg;
        hgt_raw_next  = hgt_raw_reg;
        if (we)
        begin
            unique case (gtag_pkg::gtag_reg_t'(index))
                gtag_pkg::REG_TILE_WIDTH:    tw_raw_next   = data[gtag_pkg::TILE_W-1:0];
                gtag_pkg::REG_TILE_HEIGHT:   th_raw_next   = data[gtag_pkg::TILE_W-1:0];
                gtag_pkg::REG_REGION_LEFT:   left_raw_next = data[gtag_pkg::ORIGIN_W-1:0];
                gtag_pkg::REG_REGION_TOP:    top_raw_next  = data[gtag_pkg::ORIGIN_W-1:0];
                gtag_pkg::REG_REGION_WIDTH:  wid_raw_next  = data;
                gtag_pkg::REG_REGION_HEIGHT: hgt_raw_next  = data;
                default:
                begin
                end
            endcase
        end
    end

    // Derived geometry follows the register values as they will be after this edge,
    // so the walk never sees a stale mix of old and new settings.
    always_comb
    begin
        tile_next.tw    = gtag_pkg::sat_tile(tw_raw_next);
        tile_next.th    = gtag_pkg::sat_tile(th_raw_next);
        tile_next.xhalf = {1'b0, tile_next.tw[gtag_pkg::TILE_W-1:1]};
        tile_next.xrem  = tile_next.tw - tile_next.xhalf;
        tile_next.yhalf = {1'b0, tile_next.th[gtag_pkg::TILE_W-1:1]};
        tile_next.yrem  = tile_next.th - tile_next.yhalf;
        left_next       = sat_origin(left_raw_next);
        top_next        = sat_origin(top_raw_next);
        w_next          = span_of(left_next, wid_raw_next);
        h_next          = span_of(top_next, hgt_raw_next);
        last_row_wide   = {1'b0, top_next} + h_next - 1'b1;
        last_row_next   = last_row_wide[AW-1:0];
    end

    // Raw and derived configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_raw_reg   <= gtag_pkg::TILE_RST;
            th_raw_reg   <= gtag_pkg::TILE_RST;
            left_raw_reg <= '0;
            top_raw_reg  <= '0;
            wid_raw_reg  <= gtag_pkg::SIZE_W'(gtag_pkg::REGION_SIZE_RST);
            hgt_raw_reg  <= gtag_pkg::SIZE_W'(gtag_pkg::REGION_SIZE_RST);
            left_reg     <= '0;
            top_reg      <= '0;
            w_reg        <= (AW + 1)'(RST_SPAN);
            h_reg        <= (AW + 1)'(RST_SPAN);
            last_row_reg <= AW'(RST_SPAN - 1);
            tile_reg     <= gtag_pkg::TILE_GEOM_RST;
        end
        else
        begin
            tw_raw_reg   <= tw_raw_next;
            th_raw_reg   <= th_raw_next;
            left_raw_reg <= left_raw_next;
            top_raw_reg  <= top_raw_next;
            wid_raw_reg  <= wid_raw_next;
            hgt_raw_reg  <= hgt_raw_next;
            left_reg     <= left_next;
            top_reg      <= top_next;
            w_reg        <= w_next;
            h_reg        <= h_next;
            last_row_reg <= last_row_next;
            tile_reg     <= tile_next;
        end
    end

    assign left     = left_reg;
    assign top      = top_reg;
    assign last_row = last_row_reg;
    assign w        = w_reg;
    assign h        = h_reg;
    assign tile     = tile_reg;

endmodule

FILE: src/gtag_step.sv
// Raster walk state and the single-pass source address computation.
// Depends on gtag_pkg and glass_tile_address_generator_unit_defines.svh.
`include "glass_tile_address_generator_unit_defines.svh"

module gtag_step #(
    parameter int MAX_SIZE = gtag_pkg::MAX_SIZE_DEF,
    localparam int AW = $clog2(MAX_SIZE)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   restart,
    input  logic [AW-1:0]          left,
    input  logic [AW-1:0]          top,
    input  logic [AW-1:0]          last_row,
    input  logic [AW:0]            w,
    input  logic [AW:0]            h,
    input  gtag_pkg::gtag_tile_t   tile,
    output gtag_pkg::gtag_result_t result
);

    // Centres grow by at most one tile per ten pixels; offsets may run on
    // past the half tile when the tile size shrinks in mid walk.
    localparam int CW = AW + 4;
    localparam int OW = AW + 3;
    localparam int SW = AW + 5;
    localparam int EW = ((AW + 1) > gtag_pkg::COORD_W) ? (AW + 1) : gtag_pkg::COORD_W;

    logic [AW-1:0]        col_reg, col_next;
    logic [AW-1:0]        row_reg, row_next;
    logic [AW-1:0]        held_reg, held_next;
    logic signed [CW-1:0] xc_reg, xc_next;
    logic signed [OW-1:0] xo_reg, xo_next;
    logic signed [CW-1:0] yc_reg, yc_next;
    logic signed [OW-1:0] yo_reg, yo_next;

    logic [AW-1:0]        col0, row0, col1, row2;
    logic [AW:0]          row1, col1_inc, row2_inc;
    logic                 wrap_col, row_start, frame_start, re, fe;
    logic signed [CW-1:0] yc, xc, yc_adv, xc_adv;
    logic signed [OW-1:0] yo, xo, yo_inc, xo_inc, yo_adv, xo_adv;
    logic signed [OW-1:0] yhalf_s, yrem_s, xhalf_s, xrem_s;
    logic signed [CW-1:0] th_s, tw_s;
    logic signed [SW-1:0] sy, sx, last_row_s, w_s;
    logic [AW-1:0]        sy_clamp, sx_sel;
    logic [EW-1:0]        dx_sum, dy_sum, sx_sum, sy_ext;

    // Position of this pixel after restart and region wrap.
    always_comb
    begin
        col0        = restart ? '0 : col_reg;
        row0        = restart ? '0 : row_reg;
        wrap_col    = ({1'b0, col0} >= w);
        col1        = wrap_col ? '0 : col0;
        row1        = wrap_col ? ({1'b0, row0} + 1'b1) : {1'b0, row0};
        row2        = (row1 >= h) ? '0 : row1[AW-1:0];
        row_start   = (col1 == '0);
        frame_start = row_start && (row2 == '0);
        col1_inc    = {1'b0, col1} + 1'b1;
        row2_inc    = {1'b0, row2} + 1'b1;
        re          = (col1_inc == w);
        fe          = re && (row2_inc == h);
    end

    // Row tile walk: source row chosen at the start of each row.
    always_comb
    begin
        yhalf_s    = OW'(tile.yhalf);
        yrem_s     = OW'(tile.yrem);
        th_s       = CW'(tile.th);
        last_row_s = SW'(last_row);
        yc         = frame_start ? CW'(top) : yc_reg;
        yo         = frame_start ? '0 : yo_reg;
        sy         = SW'(yc) + (SW'(yo) <<< 1);
        if (sy < 0)
        begin
            sy_clamp = '0;
        end
        else if (sy > last_row_s)
        begin
            sy_clamp = last_row;
        end
        else
        begin
            sy_clamp = sy[AW-1:0];
        end
        yo_inc = yo + OW'(1);
        if (yo_inc == yhalf_s)
        begin
            yc_adv = yc + th_s;
            yo_adv = -yrem_s;
        end
        else
        begin
            yc_adv = yc;
            yo_adv = yo_inc;
        end
        held_next = row_start ? sy_clamp : held_reg;
        yc_next   = row_start ? yc_adv : yc_reg;
        yo_next   = row_start ? yo_adv : yo_reg;
    end

    // Column tile walk: restarts at every row start.
    always_comb
    begin
        xhalf_s = OW'(tile.xhalf);
        xrem_s  = OW'(tile.xrem);
        tw_s    = CW'(tile.tw);
        w_s     = SW'(w);
        xc      = row_start ? '0 : xc_reg;
        xo      = row_start ? '0 : xo_reg;
        sx      = SW'(xc) + (SW'(xo) <<< 1);
        if (sx >= w_s)
        begin
            sx_sel = col1;
        end
        else if (sx < 0)
        begin
            sx_sel = '0;
        end
        else
        begin
            sx_sel = sx[AW-1:0];
        end
        xo_inc = xo + OW'(1);
        if (xo_inc == xhalf_s)
        begin
            xc_adv = xc + tw_s;
            xo_adv = -xrem_s;
        end
        else
        begin
            xc_adv = xc;
            xo_adv = xo_inc;
        end
        xc_next = xc_adv;
        xo_next = xo_adv;
    end

    // Advance to the following pixel.
    always_comb
    begin
        if (re)
        begin
            col_next = '0;
            row_next = fe ? '0 : row2_inc[AW-1:0];
        end
        else
        begin
            col_next = col1_inc[AW-1:0];
            row_next = row2;
        end
    end

    // Absolute coordinates of the result transaction.
    always_comb
    begin
        dx_sum           = EW'(left) + EW'(col1);
        dy_sum           = EW'(top) + EW'(row2);
        sx_sum           = EW'(left) + EW'(sx_sel);
        sy_ext           = EW'(held_next);
        result.dest_x    = dx_sum[gtag_pkg::COORD_W-1:0];
        result.dest_y    = dy_sum[gtag_pkg::COORD_W-1:0];
        result.src_x     = sx_sum[gtag_pkg::COORD_W-1:0];
        result.src_y     = sy_ext[gtag_pkg::COORD_W-1:0];
        result.row_end   = re;
        result.frame_end = fe;
    end

    // Walk state, updated once per accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
            xc_reg   <= '0;
            xo_reg   <= '0;
            yc_reg   <= '0;
            yo_reg   <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            held_reg <= held_next;
            xc_reg   <= xc_next;
            xo_reg   <= xo_next;
            yc_reg   <= yc_next;
            yo_reg   <= yo_next;
        end
    end

    // A row end must send the walk to column zero, a frame end to row zero.
    `GTAG_ASSERT_NEXT(a_row_end_clears_col, accept && re, col_reg == '0, "column not cleared after row end")
    `GTAG_ASSERT_NEXT(a_frame_end_clears_row, accept && fe, row_reg == '0, "row not cleared after frame end")
    `GTAG_ASSERT_NEXT(a_mid_row_advances, accept && !re, col_reg != '0, "column did not advance within row")
    // The source row may only change at a row start.
    `GTAG_ASSERT_NEXT(a_held_row_stable, accept && !row_start, held_reg == $past(held_reg), "source row changed mid row")

endmodule

FILE: src/gtag_obuf.sv
// Two-entry output buffer: result register plus skid stage, so the input side
// can take one more result while a finished result waits. Depends on gtag_pkg.
module gtag_obuf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  gtag_pkg::gtag_result_t in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output gtag_pkg::gtag_result_t out_data
);

    logic                   out_valid_reg, out_valid_next;
    logic                   skid_valid_reg, skid_valid_next;
    gtag_pkg::gtag_result_t out_data_reg, out_data_next;
    gtag_pkg::gtag_result_t skid_data_reg, skid_data_next;
    logic                   in_fire;
    logic                   load_out;

    // Refill the result register from the skid stage first, then from the input.
    always_comb
    begin
        in_fire         = in_valid && !skid_valid_reg;
        load_out        = !out_valid_reg || out_ready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (load_out)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_fire;
                out_data_next  = in_data;
            end
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: src/glass_tile_address_generator_unit.sv
// Glass-tile address generator: one destination pixel and its source pixel per
// transaction, walking the programmed region in raster order. A new transaction
// is taken every clock cycle while s_tready is high; its result is registered
// in the output buffer. The throughput is set by the single combinational pass
// from the walk registers through wrap, tile walk and clamping into the result
// register, and a two-entry output buffer keeps the slave side open while one
// result waits for the downstream ready. Configuration writes take effect for
// the next transaction accepted after the write edge. The walk wraps to the
// region's top-left pixel after the last pixel, or when tdata bit 0 requests a
// restart. Depends on gtag_pkg, gtag_cfg, gtag_step and gtag_obuf.
module glass_tile_address_generator_unit #(
    parameter int MAX_SIZE = gtag_pkg::MAX_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [gtag_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gtag_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Slave side.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gtag_pkg::S_TDATA_W-1:0]    s_tdata,   // [0] restart, [7:1] zero
    // Master side.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gtag_pkg::M_TDATA_W-1:0]    m_tdata,   // [11:0] dest_x, [23:12] dest_y,
                                                         // [35:24] src_x, [47:36] src_y
    output logic                              m_tlast,   // frame_end
    output logic                              m_tuser    // [0] row_end
);

    localparam int AW = $clog2(MAX_SIZE);

    logic [AW-1:0]          left, top, last_row;
    logic [AW:0]            w, h;
    gtag_pkg::gtag_tile_t   tile;
    gtag_pkg::gtag_result_t step_result;
    gtag_pkg::gtag_result_t out_result;
    logic                   accept;

    assign accept = s_tvalid && s_tready;

    // Configuration registers and derived geometry.
    gtag_cfg #(
        .MAX_SIZE (MAX_SIZE)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .we       (cfg_we),
        .index    (cfg_index),
        .data     (cfg_data),
        .left     (left),
        .top      (top),
        .last_row (last_row),
        .w        (w),
        .h        (h),
        .tile     (tile)
    );

    // Raster walk and address computation.
    gtag_step #(
        .MAX_SIZE (MAX_SIZE)
    ) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .restart  (s_tdata[0]),
        .left     (left),
        .top      (top),
        .last_row (last_row),
        .w        (w),
        .h        (h),
        .tile     (tile),
        .result   (step_result)
    );

    // Result register and skid stage.
    gtag_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (step_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {out_result.src_y, out_result.src_x, out_result.dest_y, out_result.dest_x};
    assign m_tlast = out_result.frame_end;
    assign m_tuser = out_result.row_end;

endmodule
